[design/gbs_pkg.sv]
// Package for the greedy box suppression block.
// Box record, controller command and status structs, register reset value.
// No dependencies.
package gbs_pkg;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] w;
		logic signed [15:0] h;
		logic signed [15:0] score;
		logic        [7:0]  label;
	} box_t;

	typedef struct packed {
		logic load_ready;
		logic init;
		logic scan_start;
		logic scan_sup;
		logic take;
		logic emit_en;
	} cmd_t;

	typedef struct packed {
		logic last_req;
		logic busy;
		logic emit_fire;
		logic alive_zero;
	} sts_t;

	localparam logic [16:0] THR_RESET = 17'd29491;

endpackage

[design/gbs_ctrl.sv]
// Controller state machine for greedy box suppression.
// Sequences load, best-box search, suppression scan and result issue.
// Depends on gbs_pkg.
module gbs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  gbs_pkg::sts_t sts,
	output gbs_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		LOAD,
		SEL_WAIT,
		TAKE,
		SUP_WAIT,
		EMIT
	} state_t;

	state_t        state_q;
	gbs_pkg::cmd_t cmd_q;

	assign cmd = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LOAD;
			cmd_q   <= '{load_ready: 1'b1, default: 1'b0};
		end else begin
			case (state_q)
				LOAD: begin
					cmd_q.take       <= 1'b0;
					cmd_q.init       <= sts.last_req;
					cmd_q.scan_start <= sts.last_req;
					if (sts.last_req) begin
						cmd_q.load_ready <= 1'b0;
						cmd_q.scan_sup   <= 1'b0;
						state_q          <= SEL_WAIT;
					end
				end
				SEL_WAIT: begin
					cmd_q.init       <= 1'b0;
					cmd_q.scan_start <= 1'b0;
					cmd_q.take       <= !sts.busy;
					if (!sts.busy) begin
						state_q <= TAKE;
					end
				end
				TAKE: begin
					cmd_q.init       <= 1'b0;
					cmd_q.take       <= 1'b0;
					cmd_q.scan_start <= 1'b1;
					cmd_q.scan_sup   <= 1'b1;
					state_q          <= SUP_WAIT;
				end
				SUP_WAIT: begin
					cmd_q.init       <= 1'b0;
					cmd_q.scan_start <= 1'b0;
					cmd_q.take       <= 1'b0;
					if (!sts.busy) begin
						cmd_q.emit_en <= 1'b1;
						state_q       <= EMIT;
					end
				end
				EMIT: begin
					cmd_q.init       <= 1'b0;
					cmd_q.take       <= 1'b0;
					cmd_q.scan_start <= sts.emit_fire & !sts.alive_zero;
					if (sts.emit_fire) begin
						cmd_q.emit_en <= 1'b0;
						if (sts.alive_zero) begin
							cmd_q.load_ready <= 1'b1;
							state_q          <= LOAD;
						end else begin
							cmd_q.scan_sup <= 1'b0;
							state_q        <= SEL_WAIT;
						end
					end
				end
				default: begin
					cmd_q   <= '{load_ready: 1'b1, default: 1'b0};
					state_q <= LOAD;
				end
			endcase
		end
	end

endmodule

[design/gbs_dp.sv]
// Datapath for greedy box suppression: box store, scan pipeline,
// pipelined IoU test, suppression marks and output register.
// Depends on gbs_pkg.
module gbs_dp #(
	parameter int MAX_BOXES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gbs_pkg::cmd_t      cmd,
	output gbs_pkg::sts_t      sts,
	input  logic               cfg_we,
	input  logic [16:0]        cfg_data,
	input  logic               in_valid,
	input  logic signed [15:0] left_x,
	input  logic signed [15:0] top_y,
	input  logic signed [15:0] box_width,
	input  logic signed [15:0] box_height,
	input  logic signed [15:0] confidence,
	input  logic [7:0]         class_label,
	input  logic               set_end,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] kept_left_x,
	output logic signed [15:0] kept_top_y,
	output logic signed [15:0] kept_width,
	output logic signed [15:0] kept_height,
	output logic signed [15:0] kept_confidence,
	output logic [7:0]         kept_label,
	output logic               run_end,
	output logic               overflowed
);

	localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CW = $clog2(MAX_BOXES + 1);

	gbs_pkg::box_t mem_q [MAX_BOXES];

	logic [16:0]          thr_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        alive_q;
	logic                 ovf_q;
	logic [MAX_BOXES-1:0] done_q;

	logic          issue_q, sup_q, found_q;
	logic [AW-1:0] idx_q;
	gbs_pkg::box_t best_q;
	logic [AW-1:0] best_idx_q;
	logic [29:0]   area_q;

	logic          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	gbs_pkg::box_t rd_s1;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic [14:0]   iw_s2, ih_s2, bw_s2, bh_s2;
	logic          eq_s2, eq_s3, eq_s4, eq_s5;
	logic [29:0]   inter_s3, areab_s3;
	logic [29:0]   inter_s4;
	logic [31:0]   uni_s4;
	logic          nz_s5;
	logic [48:0]   rhs_s5;
	logic [45:0]   lhs_s5;

	logic out_valid_q;
	gbs_pkg::box_t out_q;
	logic run_end_q, ovf_out_q;

	logic          in_acc, emit_fire, cand, hit, mark;
	logic signed [16:0] ra, rb, ba, bb, minr, minb;
	logic signed [15:0] maxl, maxt;
	logic signed [17:0] iw_d, ih_d;
	logic [14:0]   aw_c, ah_c;

	assign in_acc    = in_valid & cmd.load_ready;
	assign emit_fire = cmd.emit_en & (~out_valid_q | ~out_stall);

	assign sts.last_req   = in_valid & cmd.load_ready & set_end;
	assign sts.busy       = cmd.scan_start | issue_q | vld_s1 | vld_s2 | vld_s3 | vld_s4 | vld_s5;
	assign sts.emit_fire  = emit_fire;
	assign sts.alive_zero = (alive_q == '0);

	// geometry of the candidate against the kept box
	always_comb begin
		ra   = 17'(best_q.x) + 17'(best_q.w);
		rb   = 17'(rd_s1.x) + 17'(rd_s1.w);
		ba   = 17'(best_q.y) + 17'(best_q.h);
		bb   = 17'(rd_s1.y) + 17'(rd_s1.h);
		minr = (ra < rb) ? ra : rb;
		minb = (ba < bb) ? ba : bb;
		maxl = (best_q.x > rd_s1.x) ? best_q.x : rd_s1.x;
		maxt = (best_q.y > rd_s1.y) ? best_q.y : rd_s1.y;
		iw_d = 18'(minr) - 18'(maxl);
		ih_d = 18'(minb) - 18'(maxt);
		aw_c = best_q.w[15] ? 15'd0 : best_q.w[14:0];
		ah_c = best_q.h[15] ? 15'd0 : best_q.h[14:0];
	end

	assign cand = vld_s1 & ~sup_q & ~done_q[idx_s1] &
		(~found_q | (rd_s1.score > best_q.score));
	assign hit  = eq_s5 & (nz_s5 ? (49'(lhs_s5) >= rhs_s5) : (thr_q == 17'd0));
	assign mark = vld_s5 & hit & ~done_q[idx_s5];

	always_ff @(posedge clk) begin
		if (in_acc && (cnt_q < CW'(MAX_BOXES))) begin
			mem_q[cnt_q[AW-1:0]] <= '{x: left_x, y: top_y, w: box_width, h: box_height,
				score: confidence, label: class_label};
		end
		rd_s1  <= mem_q[idx_q];
		idx_s1 <= idx_q;
		if (cand) begin
			best_q     <= rd_s1;
			best_idx_q <= idx_s1;
		end
		if (cmd.take) begin
			area_q <= aw_c * ah_c;
		end
		idx_s2   <= idx_s1;
		iw_s2    <= (iw_d > 18'sd0) ? iw_d[14:0] : 15'd0;
		ih_s2    <= (ih_d > 18'sd0) ? ih_d[14:0] : 15'd0;
		bw_s2    <= rd_s1.w[15] ? 15'd0 : rd_s1.w[14:0];
		bh_s2    <= rd_s1.h[15] ? 15'd0 : rd_s1.h[14:0];
		eq_s2    <= (rd_s1.label == best_q.label);
		idx_s3   <= idx_s2;
		inter_s3 <= iw_s2 * ih_s2;
		areab_s3 <= bw_s2 * bh_s2;
		eq_s3    <= eq_s2;
		idx_s4   <= idx_s3;
		inter_s4 <= inter_s3;
		uni_s4   <= 32'(area_q) + 32'(areab_s3) - 32'(inter_s3);
		eq_s4    <= eq_s3;
		idx_s5   <= idx_s4;
		rhs_s5   <= 49'(thr_q) * 49'(uni_s4);
		lhs_s5   <= {inter_s4, 16'd0};
		nz_s5    <= (inter_s4 != 30'd0);
		eq_s5    <= eq_s4;
		if (emit_fire) begin
			out_q     <= best_q;
			run_end_q <= (alive_q == '0);
			ovf_out_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= gbs_pkg::THR_RESET;
			cnt_q       <= '0;
			alive_q     <= '0;
			ovf_q       <= 1'b0;
			done_q      <= '0;
			issue_q     <= 1'b0;
			sup_q       <= 1'b0;
			found_q     <= 1'b0;
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_data;
			end
			if (in_acc) begin
				if (cnt_q < CW'(MAX_BOXES)) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.init) begin
				alive_q <= cnt_q;
			end
			if (cmd.scan_start) begin
				issue_q <= 1'b1;
				idx_q   <= '0;
				sup_q   <= cmd.scan_sup;
				if (!cmd.scan_sup) begin
					found_q <= 1'b0;
				end
			end else if (issue_q) begin
				if (CW'(idx_q) == cnt_q - 1'b1) begin
					issue_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			vld_s1 <= issue_q;
			vld_s2 <= vld_s1 & sup_q;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			if (cand) begin
				found_q <= 1'b1;
			end
			if (cmd.take) begin
				done_q[best_idx_q] <= 1'b1;
				alive_q            <= alive_q - 1'b1;
			end
			if (mark) begin
				done_q[idx_s5] <= 1'b1;
				alive_q        <= alive_q - 1'b1;
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
				if (alive_q == '0) begin
					done_q <= '0;
					cnt_q  <= '0;
					ovf_q  <= 1'b0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign kept_left_x     = out_q.x;
	assign kept_top_y      = out_q.y;
	assign kept_width      = out_q.w;
	assign kept_height     = out_q.h;
	assign kept_confidence = out_q.score;
	assign kept_label      = out_q.label;
	assign run_end         = run_end_q;
	assign overflowed      = ovf_out_q;

endmodule

[design/greedy_box_suppression.sv]
// Greedy box suppression, top level. Boxes load one per cycle while in_stall is low.
// After the set's last request, each survivor takes one store pass over the n stored
// boxes to find the best remaining box and one pipelined IoU pass; the store has one
// read port. Reset clears control, counts, marks and the threshold (29491); the box
// store is not cleared. Depends on gbs_pkg, gbs_ctrl, gbs_dp.
module greedy_box_suppression #(
	parameter int MAX_BOXES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [16:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] left_x,
	input  logic signed [15:0] top_y,
	input  logic signed [15:0] box_width,
	input  logic signed [15:0] box_height,
	input  logic signed [15:0] confidence,
	input  logic [7:0]         class_label,
	input  logic               set_end,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] kept_left_x,
	output logic signed [15:0] kept_top_y,
	output logic signed [15:0] kept_width,
	output logic signed [15:0] kept_height,
	output logic signed [15:0] kept_confidence,
	output logic [7:0]         kept_label,
	output logic               run_end,
	output logic               overflowed
);

	gbs_pkg::cmd_t cmd;
	gbs_pkg::sts_t sts;

	assign in_stall = ~cmd.load_ready;

	gbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	gbs_dp #(
		.MAX_BOXES (MAX_BOXES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.left_x          (left_x),
		.top_y           (top_y),
		.box_width       (box_width),
		.box_height      (box_height),
		.confidence      (confidence),
		.class_label     (class_label),
		.set_end         (set_end),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kept_left_x     (kept_left_x),
		.kept_top_y      (kept_top_y),
		.kept_width      (kept_width),
		.kept_height     (kept_height),
		.kept_confidence (kept_confidence),
		.kept_label      (kept_label),
		.run_end         (run_end),
		.overflowed      (overflowed)
	);

endmodule
